// ===== src/matte_alpha_edge_feather_core_assert.svh =====
// Assertion macros for the matte alpha edge feather core
`ifndef MATTE_ALPHA_EDGE_FEATHER_CORE_ASSERT_SVH
`define MATTE_ALPHA_EDGE_FEATHER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define MAFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mafe assertion failed");

// next-cycle implication, held off during reset
`define MAFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mafe assertion failed");

// next-cycle implication, also checked across reset
`define MAFE_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mafe assertion failed");

`endif

// ===== src/mafe_pkg.sv =====
// Types, constants and helper functions shared by the matte alpha core
package mafe_pkg;

  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 12;
  localparam int BAND_W  = 5;
  localparam int PROD_W  = 13;
  localparam int RECIP_W = 19;
  localparam int RECIP_SHIFT = 18;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK_ENABLE  = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic [7:0] fg_ch0;
    logic [7:0] fg_ch1;
    logic [7:0] fg_ch2;
    logic [7:0] bg_ch0;
    logic [7:0] bg_ch1;
    logic [7:0] bg_ch2;
    logic [7:0] mask_value;
  } pixel_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic       frame_end;
  } result_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [7:0]        alpha;
    logic [BAND_W-1:0] dx;
    logic [BAND_W-1:0] dy;
    logic [BAND_W-1:0] bw;
    logic [BAND_W-1:0] bh;
    logic              frame_end;
  } job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // min(20, size/10), at least 1; size/10 via *205 >> 11, exact below 200
  function automatic logic [BAND_W-1:0] band_of(input logic [DIM_W-1:0] s);
    logic [15:0]       p;
    logic [BAND_W-1:0] b;
    p = 16'(s[7:0]) * 16'd205;
    if (s >= DIM_W'(200)) b = BAND_W'(20);
    else b = p[15:11];
    if (b == '0) b = BAND_W'(1);
    return b;
  endfunction

  function automatic logic [BAND_W-1:0] edge_dist(input logic [CNT_W-1:0] pos,
                                                  input logic [DIM_W-1:0] s,
                                                  input logic [BAND_W-1:0] band);
    logic [DIM_W-1:0] far;
    logic [DIM_W-1:0] d;
    logic [BAND_W-1:0] r;
    if ({1'b0, pos} >= s - DIM_W'(1)) far = '0;
    else far = s - DIM_W'(1) - {1'b0, pos};
    d = ({1'b0, pos} < far) ? {1'b0, pos} : far;
    r = (d > DIM_W'(band)) ? band : d[BAND_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [7:0] ramp(input logic [9:0] d);
    logic [9:0] t;
    logic [7:0] r;
    t = '0;
    if (d < 10'd10) begin
      r = '0;
    end else if (d < 10'd25) begin
      t = (d - 10'd10) << 2;
      r = t[7:0];
    end else if (d < 10'd35) begin
      t = (d - 10'd25) * 10'd20 + 10'd60;
      r = t[7:0];
    end else begin
      r = 8'd255;
    end
    return r;
  endfunction

  // ceil(2^18 / b); exact floor(n/b) for n below 13797
  function automatic logic [RECIP_W-1:0] recip(input logic [BAND_W-1:0] b);
    logic [RECIP_W-1:0] r;
    case (b)
      5'd1:    r = 19'd262144;
      5'd2:    r = 19'd131072;
      5'd3:    r = 19'd87382;
      5'd4:    r = 19'd65536;
      5'd5:    r = 19'd52429;
      5'd6:    r = 19'd43691;
      5'd7:    r = 19'd37450;
      5'd8:    r = 19'd32768;
      5'd9:    r = 19'd29128;
      5'd10:   r = 19'd26215;
      5'd11:   r = 19'd23832;
      5'd12:   r = 19'd21846;
      5'd13:   r = 19'd20165;
      5'd14:   r = 19'd18725;
      5'd15:   r = 19'd17477;
      5'd16:   r = 19'd16384;
      5'd17:   r = 19'd15421;
      5'd18:   r = 19'd14564;
      5'd19:   r = 19'd13798;
      5'd20:   r = 19'd13108;
      default: r = 19'd262144;
    endcase
    return r;
  endfunction

endpackage

// ===== src/mafe_front.sv =====
// Front end: config registers, raster counters, distance ramp and edge classification
module mafe_front import mafe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  pixel_t           in_data,
  input  logic             q_full,
  output logic             q_push,
  output job_t             job
);

  logic [DIM_W-1:0]  frame_width;
  logic [DIM_W-1:0]  frame_height;
  logic              mask_enable;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  column_count_next;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  row_count_next;

  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [BAND_W-1:0] bw;
  logic [BAND_W-1:0] bh;
  logic [9:0]        chan_sum;
  logic              masked;
  logic              last_col;
  logic              last_row;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    w        = clamp_dim(frame_width);
    h        = clamp_dim(frame_height);
    bw       = band_of(w);
    bh       = band_of(h);
    chan_sum = 10'(absdiff(in_data.fg_ch0, in_data.bg_ch0))
             + 10'(absdiff(in_data.fg_ch1, in_data.bg_ch1))
             + 10'(absdiff(in_data.fg_ch2, in_data.bg_ch2));
    masked   = mask_enable && (in_data.mask_value == 8'd0);
    last_col = {1'b0, column_count} >= w - DIM_W'(1);
    last_row = {1'b0, row_count} >= h - DIM_W'(1);

    job.alpha     = masked ? 8'd0 : ramp(chan_sum);
    job.dx        = edge_dist(column_count, w, bw);
    job.dy        = edge_dist(row_count, h, bh);
    job.bw        = bw;
    job.bh        = bh;
    job.frame_end = last_col && last_row;

    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + CNT_W'(1);
    end else begin
      column_count_next = column_count + CNT_W'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      mask_enable  <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          REG_MASK_ENABLE:  mask_enable  <= cfg_data[0];
          default: ;
        endcase
      end
      if (q_push) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
    end
  end

endmodule

// ===== src/mafe_queue.sv =====
// Short request queue between front and back
module mafe_queue import mafe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ===== src/mafe_back.sv =====
// Back end: edge scaling by reciprocal multiply, minimum and output register
module mafe_back import mafe_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  job_t    q_head,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic              en;
  logic              s1_valid;
  logic [PROD_W-1:0] s1_px;
  logic [PROD_W-1:0] s1_py;
  logic [BAND_W-1:0] s1_bw;
  logic [BAND_W-1:0] s1_bh;
  logic              s1_end;
  logic              s2_valid;
  logic [7:0]        s2_qx;
  logic [7:0]        s2_qy;
  logic              s2_end;
  logic [31:0]       prod_x;
  logic [31:0]       prod_y;

  assign en    = !(out_valid && out_stall);
  assign q_pop = en && !q_empty;

  assign prod_x = 32'(s1_px) * 32'(recip(s1_bw));
  assign prod_y = 32'(s1_py) * 32'(recip(s1_bh));

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= PROD_W'(q_head.alpha) * PROD_W'(q_head.dx);
      s1_py  <= PROD_W'(q_head.alpha) * PROD_W'(q_head.dy);
      s1_bw  <= q_head.bw;
      s1_bh  <= q_head.bh;
      s1_end <= q_head.frame_end;
      s2_qx  <= prod_x[RECIP_SHIFT +: 8];
      s2_qy  <= prod_y[RECIP_SHIFT +: 8];
      s2_end <= s1_end;
      out_data.alpha     <= (s2_qx < s2_qy) ? s2_qx : s2_qy;
      out_data.frame_end <= s2_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

endmodule

// ===== src/matte_alpha_edge_feather_core.sv =====
// Top level of the matte alpha edge feather core
//
//   channel | dir | payload   | handshake
//   --------+-----+-----------+--------------------------
//   in      | in  | pixel_t   | in_valid / in_stall
//   out     | out | result_t  | out_valid / out_stall
//   cfg     | in  | 13b data  | cfg_we, cfg_index
//
// One pixel per cycle while neither in_stall nor out_stall holds the flow; an accepted
// request is written into the queue, then passes the product, reciprocal multiply
// and min stages into the output register.
// The back pipeline is held as a whole while a result waits under out_stall.
// in_stall rises only when the four-entry queue is full.
// rst clears counters, queue, stage valids and sets registers to 640/480/off.
module matte_alpha_edge_feather_core import mafe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  pixel_t           in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_data
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  job_t push_job;
  job_t head_job;

  mafe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .job       (push_job)
  );

  mafe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_job),
    .pop       (q_pop),
    .head      (head_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  mafe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/mafe_checker.sv =====
// Port-level checker for the matte alpha edge feather core, with its bind
`include "matte_alpha_edge_feather_core_assert.svh"

module mafe_checker import mafe_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input result_t          out_data
);

  logic [3:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_take && !out_take) begin
      pending <= pending + 4'd1;
    end else if (out_take && !in_take) begin
      pending <= pending - 4'd1;
    end
  end

  // a held result keeps its value
  `MAFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // no result without an accepted request behind it
  `MAFE_ASSERT_NOW(a_no_phantom, out_valid, pending != 4'd0)
  // queue plus three stages bound what is in flight
  `MAFE_ASSERT_NOW(a_capacity, 1'b1, pending <= 4'd7)
  // reset empties the block and opens the input
  `MAFE_ASSERT_ALWAYS_NEXT(a_reset_clear, rst, !out_valid && !in_stall)

endmodule

bind matte_alpha_edge_feather_core mafe_checker u_mafe_checker (.*);

// ===== dv/tb_matte_alpha_edge_feather_core.sv =====
// Self-checking testbench for the matte alpha edge feather core with a scoreboard class
module tb_matte_alpha_edge_feather_core;
  import mafe_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int ITEMS = 800;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  class alpha_scoreboard;
    int unsigned width_reg;
    int unsigned height_reg;
    bit          mask_on;
    int unsigned col;
    int unsigned row;
    int unsigned mismatches;
    result_t     alpha_due[$];

    function new();
      width_reg  = 32'(WIDTH_RESET);
      height_reg = 32'(HEIGHT_RESET);
      mask_on    = 1'b0;
      col        = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = 32'(val);
        REG_FRAME_HEIGHT: height_reg = 32'(val);
        REG_MASK_ENABLE:  mask_on = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return alpha_due.size();
    endfunction

    function int unsigned size_clamp(input int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function int unsigned band_for(input int unsigned s);
      int unsigned b;
      b = s / 10;
      if (b > 20) b = 20;
      if (b < 1) b = 1;
      return b;
    endfunction

    // distance to the nearer edge, capped at the band
    function int unsigned edge_gap(input int unsigned pos, input int unsigned s,
                                   input int unsigned band);
      int unsigned far_side;
      int unsigned d;
      far_side = (pos >= s - 1) ? 0 : s - 1 - pos;
      d = (pos < far_side) ? pos : far_side;
      return (d > band) ? band : d;
    endfunction

    function int unsigned chan_gap(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function int unsigned ramp_level(input int unsigned d);
      if (d < 10) return 0;
      if (d < 25) return (d - 10) * 4;
      if (d < 35) return (d - 25) * 20 + 60;
      return 255;
    endfunction

    function void note_pixel(input pixel_t p);
      int unsigned w, h, a, d, bw, bh, ax, ay;
      bit          last_col, last_row;
      result_t     e;
      w = size_clamp(width_reg);
      h = size_clamp(height_reg);
      a = 0;
      if (!(mask_on && p.mask_value == 8'd0)) begin
        d = chan_gap(p.fg_ch0, p.bg_ch0) + chan_gap(p.fg_ch1, p.bg_ch1)
          + chan_gap(p.fg_ch2, p.bg_ch2);
        a  = ramp_level(d);
        bw = band_for(w);
        bh = band_for(h);
        ax = (a * edge_gap(col, w, bw)) / bw;
        ay = (a * edge_gap(row, h, bh)) / bh;
        a  = (ax < ay) ? ax : ay;
      end
      last_col    = col >= w - 1;
      last_row    = row >= h - 1;
      e.alpha     = a[7:0];
      e.frame_end = last_col && last_row;
      alpha_due   = {alpha_due, e};
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_alpha(input result_t r);
      result_t e;
      if (alpha_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: alpha=%0d frame_end=%0b", r.alpha, r.frame_end);
        return;
      end
      e = alpha_due.pop_front();
      if (r.alpha !== e.alpha || r.frame_end !== e.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: alpha exp %0d got %0d, frame_end exp %0b got %0b",
                   e.alpha, r.alpha, e.frame_end, r.frame_end);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  pixel_t           in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  result_t          out_data;

  alpha_scoreboard sb;
  int unsigned     sent = 0;
  int unsigned     cycles = 0;
  bit              quiet = 1'b0;
  bit              hold_req = 1'b0;
  bit              hold_done = 1'b0;
  int unsigned     hold_left = 0;

  matte_alpha_edge_feather_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_pixel(in_data);
      if (out_valid && !out_stall) sb.check_alpha(out_data);
    end
  end

  // receiver: random stalls, plus one long hold-off to back the core up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  function automatic pixel_t px(input logic [7:0] f0, input logic [7:0] f1,
                                input logic [7:0] f2, input logic [7:0] b0,
                                input logic [7:0] b1, input logic [7:0] b2,
                                input logic [7:0] m);
    pixel_t p;
    p.fg_ch0 = f0;
    p.fg_ch1 = f1;
    p.fg_ch2 = f2;
    p.bg_ch0 = b0;
    p.bg_ch1 = b1;
    p.bg_ch2 = b2;
    p.mask_value = m;
    return p;
  endfunction

  // mostly near-matching colours so the distance lands on the ramp
  function automatic pixel_t rand_pixel();
    pixel_t p;
    bit     near;
    p.fg_ch0 = 8'($urandom);
    p.fg_ch1 = 8'($urandom);
    p.fg_ch2 = 8'($urandom);
    near = $urandom_range(0, 3) != 0;
    p.bg_ch0 = near ? p.fg_ch0 + 8'($urandom_range(0, 12)) : 8'($urandom);
    p.bg_ch1 = near ? p.fg_ch1 - 8'($urandom_range(0, 12)) : 8'($urandom);
    p.bg_ch2 = near ? p.fg_ch2 + 8'($urandom_range(0, 12)) : 8'($urandom);
    p.mask_value = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
    return p;
  endfunction

  function automatic logic [DIM_W-1:0] pick_size(input int unsigned small_max);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 13'd199;
          1: return 13'd200;
          2: return 13'd255;
          3: return 13'd256;
          4: return 13'd19;
          default: return 13'd20;
        endcase
      end
      1: return $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF;
      default: return 13'($urandom_range(0, small_max));
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic send_pixel(input pixel_t p);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int unsigned phase;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 14x3 frame, mask on: row 0 and the first pixel of row 1 as filler, then ramp breaks in the interior of row 1
    write_reg(REG_FRAME_WIDTH, 13'd14);
    write_reg(REG_FRAME_HEIGHT, 13'd3);
    write_reg(REG_MASK_ENABLE, 13'd1);
    write_reg(REG_NONE, 13'h1FFF);
    repeat (15) send_pixel(rand_pixel());
    send_pixel(px(8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'd7, 8'hFF));
    send_pixel(px(8'd9, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1));
    send_pixel(px(8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128));
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd8, 8'd8, 8'd8, 8'd2));
    send_pixel(px(8'd0, 8'd0, 8'd25, 8'd0, 8'd0, 8'd0, 8'd4));
    send_pixel(px(8'd20, 8'd0, 8'd14, 8'd0, 8'd0, 8'd0, 8'd8));
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0, 8'd35, 8'd0, 8'd16));
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd32));
    send_pixel(px(8'd0, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'd64));
    send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0));
    send_pixel(px(8'hFF, 8'd0, 8'hFF, 8'd0, 8'hFF, 8'd0, 8'd1));
    send_pixel(px(8'd3, 8'd4, 8'd5, 8'd0, 8'd0, 8'd0, 8'hFF));
    drain();

    // zero sizes act as one: every pixel ends a frame
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(REG_MASK_ENABLE, 13'd0);
    repeat (3) send_pixel(px(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0, 8'd0));
    drain();

    // oversize registers clamp to the largest frame
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(REG_MASK_ENABLE, 13'h1FFF);
    write_reg(REG_NONE, 13'd0);
    repeat (20) send_pixel(rand_pixel());

    phase = 0;
    while (sent < ITEMS) begin
      drain();
      if ($urandom_range(0, 9) < 7) write_reg(REG_FRAME_WIDTH, pick_size(48));
      if ($urandom_range(0, 9) < 7) write_reg(REG_FRAME_HEIGHT, pick_size(24));
      write_reg(REG_MASK_ENABLE, 13'($urandom));
      if ($urandom_range(0, 4) == 0) write_reg(REG_NONE, 13'($urandom));
      if (phase == 2) begin
        quiet    <= 1'b1;
        hold_req <= 1'b1;
      end
      if (phase == 5) quiet <= 1'b0;
      repeat ($urandom_range(20, 100)) send_pixel(rand_pixel());
      phase++;
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
